/* sv/pid_step_pkg.sv */
// ----------------------------------------------------------------------------
// pid_step_pkg
// Shared types and constants of the PID step unit.
// ----------------------------------------------------------------------------
package pid_step_pkg;

  localparam int unsigned DATA_W   = 16;  // sample and gain width
  localparam int unsigned ERR_W    = 17;  // set_point - feedback
  localparam int unsigned DIF_W    = 18;  // error - last error
  localparam int unsigned DER_W    = 34;  // derivative, (error delta) * inv_dt
  localparam int unsigned INTEG_W  = 48;  // integral accumulator
  localparam int unsigned SUM_W    = 52;  // Q.8 control sum before the final shift
  localparam int unsigned CTL_W    = 32;  // control value
  localparam int unsigned MUL_W    = 64;  // multiplicand / product width
  localparam int unsigned MB_W     = 18;  // multiplier operand width (signed)
  localparam int unsigned MUL_DIGITS = MB_W / 2;  // radix-4 digits per product
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [DATA_W-1:0] DT_FRAC_RST = 16'd7;
  localparam logic [DATA_W-1:0] INV_DT_RST  = 16'd10000;

  typedef enum logic [ADDR_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_DT_FRAC    = 3'd3,
    REG_INV_DT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_integ;
    logic signed [DATA_W-1:0] gain_deriv;
    logic        [DATA_W-1:0] dt_frac;
    logic        [DATA_W-1:0] inv_dt;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_INTEG = 3'd0,
    OP_DERIV = 3'd1,
    OP_PROP  = 3'd2,
    OP_KI    = 3'd3,
    OP_KD    = 3'd4
  } op_t;

endpackage

/* sv/pid_controller_step_unit.sv */
// ----------------------------------------------------------------------------
// pid_controller_step_unit
// Discrete parallel PID controller, one control step per input sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per sample; in_tdata = {feedback, set_point}.
//   out_* : one transfer per sample; out_tdata = control_value,
//           out_tuser = saturated (integral or output clamped this step).
//   cfg_* : register writes (gains Q8.8, dt_frac Q0.16, inv_dt), to be
//           made only while no sample is in flight; the block does not enforce this.
// Timing:
//   The five products (err*dt, delta*inv_dt, kp*err, ki*integral,
//   kd*deriv) share one radix-4 Booth serial multiplier, nine digits
//   each, loaded, run and written back one product after another.
//   A new sample is taken only once the previous result has been written
//   to the output register.
// Reset:
//   Integral and last error clear, gains clear, dt_frac = 7, inv_dt = 10000.
// Stall:
//   The result waits in the output register; the next sample is still
//   accepted and computed, and only its final writeback waits for space.
// ----------------------------------------------------------------------------
module pid_controller_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input samples
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,   // [15:0] set_point, [31:16] feedback
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [31:0] control_value
  output logic                                out_tuser,  // [0] saturated
  // configuration
  input  logic                                cfg_we,
  input  logic [pid_step_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [pid_step_pkg::DATA_W-1:0]     cfg_wdata
);
  import pid_step_pkg::*;

  cfg_t      cfg;
  mul_stat_t mul_stat;
  logic      mul_start;
  logic [MUL_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [MUL_W-1:0] prod;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [ERR_W-1:0]   err_r, err_nxt;        // current error
  logic [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic [DIF_W-1:0]   dif_r, dif_nxt;        // error - last error
  logic [INTEG_W-1:0] integ_r, integ_nxt;
  logic [DER_W-1:0]   deriv_r, deriv_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CTL_W-1:0]   out_data_r, out_data_nxt;
  logic               out_sat_r, out_sat_nxt;

  logic [ERR_W-1:0]   err_w;
  logic [INTEG_W:0]   integ_add;
  logic               ctl_ovf;
  logic [CTL_W-1:0]   ctl_w;

  pid_step_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  pid_step_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .stat  (mul_stat),
    .prod  (prod)
  );

  // error from the sample fields
  assign err_w = {in_tdata[15], in_tdata[15:0]} - {in_tdata[31], in_tdata[31:16]};

  // integral update with 48-bit saturation
  assign integ_add = {integ_r[INTEG_W-1], integ_r} + prod[INTEG_W:0];

  // final arithmetic shift by 8 and clamp to 32 bits
  assign ctl_ovf = !((&sum_r[SUM_W-1:CTL_W+7]) || !(|sum_r[SUM_W-1:CTL_W+7]));
  assign ctl_w   = ctl_ovf ? (sum_r[SUM_W-1] ? {1'b1, {(CTL_W-1){1'b0}}}
                                             : {1'b0, {(CTL_W-1){1'b1}}})
                           : sum_r[CTL_W+7:8];

  // operand select for the shared multiplier
  always_comb begin
    unique case (op_r)
      OP_INTEG: begin
        mul_a = {{(MUL_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {2'b00, cfg.dt_frac};
      end
      OP_DERIV: begin
        mul_a = {{(MUL_W-DIF_W){dif_r[DIF_W-1]}}, dif_r};
        mul_b = {2'b00, cfg.inv_dt};
      end
      OP_PROP: begin
        mul_a = {{(MUL_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{2{cfg.gain_prop[DATA_W-1]}}, cfg.gain_prop};
      end
      OP_KI: begin
        mul_a = {{(MUL_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r};
        mul_b = {{2{cfg.gain_integ[DATA_W-1]}}, cfg.gain_integ};
      end
      OP_KD: begin
        mul_a = {{(MUL_W-DER_W){deriv_r[DER_W-1]}}, deriv_r};
        mul_b = {{2{cfg.gain_deriv[DATA_W-1]}}, cfg.gain_deriv};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    err_nxt       = err_r;
    last_err_nxt  = last_err_r;
    dif_nxt       = dif_r;
    integ_nxt     = integ_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    mul_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          err_nxt      = err_w;
          dif_nxt      = {err_w[ERR_W-1], err_w} - {last_err_r[ERR_W-1], last_err_r};
          last_err_nxt = err_w;
          sat_nxt      = 1'b0;
          op_nxt       = OP_INTEG;
          state_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mul_start = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (mul_stat.done) begin
          unique case (op_r)
            OP_INTEG: begin
              if (integ_add[INTEG_W] != integ_add[INTEG_W-1]) begin
                integ_nxt = integ_add[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                               : {1'b0, {(INTEG_W-1){1'b1}}};
                sat_nxt   = 1'b1;
              end else begin
                integ_nxt = integ_add[INTEG_W-1:0];
              end
            end
            OP_DERIV: deriv_nxt = prod[DER_W-1:0];
            OP_PROP:  sum_nxt   = prod[SUM_W-1:0];
            OP_KI:    sum_nxt   = sum_r + {{(SUM_W-INTEG_W){prod[MUL_W-1]}},
                                           prod[MUL_W-1:16]};
            OP_KD:    sum_nxt   = sum_r + prod[SUM_W-1:0];
            default:  sum_nxt   = sum_r;
          endcase
          if (op_r == OP_KD) begin
            state_nxt = ST_DONE;
          end else begin
            op_nxt    = op_t'(op_r + 3'd1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = ctl_w;
          out_sat_nxt   = sat_r || ctl_ovf;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_INTEG;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      last_err_r  <= last_err_nxt;
      integ_r     <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    dif_r      <= dif_nxt;
    deriv_r    <= deriv_nxt;
    sum_r      <= sum_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // multiplier is only restarted once its previous product is done
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // a finished product is only seen while the sequencer waits for it
  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == ST_RUN))
    else $error("multiplier done outside run state");

  // a new result only comes out of the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |-> ($past(state_r) == ST_DONE))
    else $error("result written outside final step");

  // the integral only moves while an integral product is written back
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN || op_r != OP_INTEG) |=> $stable(integ_r))
    else $error("integral changed outside its update");

endmodule

/* sv/pid_step_cfg.sv */
// ----------------------------------------------------------------------------
// pid_step_cfg
// Gain and timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pid_step_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pid_step_pkg::ADDR_W-1:0]      cfg_addr,
  input  logic [pid_step_pkg::DATA_W-1:0]      cfg_wdata,
  output pid_step_pkg::cfg_t                   cfg_o
);
  import pid_step_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_PROP:  regs_nxt.gain_prop  = cfg_wdata;
        REG_GAIN_INTEG: regs_nxt.gain_integ = cfg_wdata;
        REG_GAIN_DERIV: regs_nxt.gain_deriv = cfg_wdata;
        REG_DT_FRAC:    regs_nxt.dt_frac    = cfg_wdata;
        REG_INV_DT:     regs_nxt.inv_dt     = cfg_wdata;
        default:        regs_nxt = regs_r;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.gain_prop  <= '0;
      regs_r.gain_integ <= '0;
      regs_r.gain_deriv <= '0;
      regs_r.dt_frac    <= DT_FRAC_RST;
      regs_r.inv_dt     <= INV_DT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_o = regs_r;

endmodule

/* sv/pid_step_mul.sv */
// ----------------------------------------------------------------------------
// pid_step_mul
// Radix-4 Booth serial multiplier: one 2-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module pid_step_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [pid_step_pkg::MUL_W-1:0]        a_in,   // signed multiplicand
  input  logic [pid_step_pkg::MB_W-1:0]         b_in,   // signed multiplier
  output pid_step_pkg::mul_stat_t               stat,
  output logic [pid_step_pkg::MUL_W-1:0]        prod
);
  import pid_step_pkg::*;

  logic [MUL_W-1:0] a_r, a_nxt;
  logic [MB_W:0]    b_r, b_nxt;      // extra low bit holds b[2i-1]
  logic [MUL_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MUL_W-1:0] mag;
  logic             neg;

  // Booth digit recode
  always_comb begin
    unique case (b_r[2:0])
      3'b001, 3'b010: begin mag = a_r;       neg = 1'b0; end
      3'b011:         begin mag = a_r << 1;  neg = 1'b0; end
      3'b100:         begin mag = a_r << 1;  neg = 1'b1; end
      3'b101, 3'b110: begin mag = a_r;       neg = 1'b1; end
      default:        begin mag = '0;        neg = 1'b0; end
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = {b_in, 1'b0};
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (mag ^ {MUL_W{neg}}) + MUL_W'(neg);
      a_nxt   = a_r << 2;
      b_nxt   = {{2{b_r[MB_W]}}, b_r[MB_W:2]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PID step unit. Samples go in over the input
// stream; each control value is compared with a cycle-free software copy of
// the controller (error, clamped integral, derivative, gained sum, clamped
// output) that tracks gains, period and state through every register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pid_step_pkg::*;

  localparam int unsigned NUM_REGS   = int'(REG_INV_DT) + 1;
  localparam int unsigned ADDR_SPAN  = 1 << ADDR_W;
  localparam logic [ADDR_SPAN-1:0] KNOWN_MASK = ADDR_SPAN'((1 << NUM_REGS) - 1);
  localparam logic [ADDR_SPAN-1:0] ALL_MASK   = '1;
  localparam logic [ADDR_SPAN-1:0] GAIN_MASK  =
    ADDR_SPAN'((1 << REG_GAIN_PROP) | (1 << REG_GAIN_INTEG) | (1 << REG_GAIN_DERIV));

  localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] S16_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] GAIN_ONE = 16'sh0100;  // 1.0 in Q8.8

  localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam longint CTL_HI   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint CTL_LO   = -CTL_HI - 1;

  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned RAMP_ITEMS      = 40;
  localparam int unsigned SQUEEZE_FIRST   = 200;   // first long sink stall
  localparam int unsigned SQUEEZE_EVERY   = 700;
  localparam int unsigned SQUEEZE_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES    = 120;   // outlasts a full control step
  // About 1.4k samples plus worst gaps and stalls stay under 5 ms of
  // simulated time. 100 ms is several times that.
  localparam longint TIMEOUT_NS = 100_000_000;

  typedef struct packed {
    logic [CTL_W-1:0] ctl;
    logic             sat;
  } ctl_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the controller registers and state, predicts one
  // control value per accepted sample and checks results in order.
  // --------------------------------------------------------------------------
  class pid_scoreboard;
    cfg_t          regs;
    longint        integ_acc;   // 48-bit integral, held sign-extended
    longint        prev_err;
    ctl_result_t   due_q[$];
    int unsigned   n_errors;

    function new();
      regs.gain_prop  = '0;
      regs.gain_integ = '0;
      regs.gain_deriv = '0;
      regs.dt_frac    = DT_FRAC_RST;
      regs.inv_dt     = INV_DT_RST;
      integ_acc = 0;
      prev_err  = 0;
      n_errors  = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_config(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
      case (reg_idx_t'(idx))
        REG_GAIN_PROP:  regs.gain_prop  = val;
        REG_GAIN_INTEG: regs.gain_integ = val;
        REG_GAIN_DERIV: regs.gain_deriv = val;
        REG_DT_FRAC:    regs.dt_frac    = val;
        REG_INV_DT:     regs.inv_dt     = val;
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    // one control step for an accepted sample
    function void note_sample(logic signed [DATA_W-1:0] sp,
                              logic signed [DATA_W-1:0] fb);
      longint      err;
      longint      integ;
      longint      deriv;
      longint      total;
      longint      ctl;
      ctl_result_t res;
      res.sat = 1'b0;
      err   = longint'(sp) - longint'(fb);
      integ = integ_acc + err * longint'(regs.dt_frac);
      if (integ > INTEG_HI) begin
        integ = INTEG_HI;
        res.sat = 1'b1;
      end
      if (integ < INTEG_LO) begin
        integ = INTEG_LO;
        res.sat = 1'b1;
      end
      integ_acc = integ;
      deriv = (err - prev_err) * longint'(regs.inv_dt);
      // >>> on a signed longint floors, as the hardware shift does
      total = longint'($signed(regs.gain_prop)) * err
            + ((longint'($signed(regs.gain_integ)) * integ) >>> 16)
            + longint'($signed(regs.gain_deriv)) * deriv;
      ctl = total >>> 8;
      if (ctl > CTL_HI) begin
        ctl = CTL_HI;
        res.sat = 1'b1;
      end
      if (ctl < CTL_LO) begin
        ctl = CTL_LO;
        res.sat = 1'b1;
      end
      prev_err = err;
      res.ctl  = ctl[CTL_W-1:0];
      due_q.push_back(res);
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= 100)
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [CTL_W-1:0] ctl, logic sat);
      ctl_result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result ctl=%0d sat=%0b", $signed(ctl), sat));
      end else begin
        want = due_q.pop_front();
        if (ctl !== want.ctl)
          report($sformatf("control_value %0d, want %0d",
                           $signed(ctl), $signed(want.ctl)));
        if (sat !== want.sat)
          report($sformatf("saturated %0b, want %0b (ctl %0d)",
                           sat, want.sat, $signed(want.ctl)));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [31:0]         in_tdata   = '0;   // [15:0] set_point, [31:16] feedback
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [31:0]         out_tdata;         // [31:0] control_value
  logic                out_tuser;         // [0] saturated
  logic                cfg_we     = 1'b0;
  logic [ADDR_W-1:0]   cfg_addr   = '0;
  logic [DATA_W-1:0]   cfg_wdata  = '0;

  pid_scoreboard sb;
  bit            tx_idle_en = 1'b1;  // sender inserts gaps
  bit            rx_idle_en = 1'b1;  // sink drops ready at random
  int unsigned   n_results  = 0;

  pid_controller_step_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: only reached if the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[pid_controller_step_unit] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_edge();
    case ($urandom_range(0, 3))
      0:       return S16_MIN;
      1:       return S16_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // gains: extremes, zero, realistic small Q8.8, or anything
  function automatic logic signed [DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0:       return S16_MAX;
      1:       return S16_MIN;
      2:       return '0;
      3, 4, 5: return DATA_W'($urandom_range(0, 1024)) - 16'sd512;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // dt_frac / inv_dt: zero and full scale included
  function automatic logic [DATA_W-1:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'(1);
      3, 4:    return DATA_W'($urandom_range(1, 255));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes only with nothing in flight. Bits of mask pick the
  // indexes written; unmapped ones get random data and must be ignored.
  task automatic load_config(input cfg_t setting, input logic [ADDR_SPAN-1:0] mask);
    logic [DATA_W-1:0] val;
    in_tvalid <= 1'b0;
    wait_idle();
    for (int i = 0; i < ADDR_SPAN; i++) begin
      if (mask[i]) begin
        case (reg_idx_t'(i))
          REG_GAIN_PROP:  val = setting.gain_prop;
          REG_GAIN_INTEG: val = setting.gain_integ;
          REG_GAIN_DERIV: val = setting.gain_deriv;
          REG_DT_FRAC:    val = setting.dt_frac;
          REG_INV_DT:     val = setting.inv_dt;
          default:        val = DATA_W'($urandom);
        endcase
        cfg_we    <= 1'b1;
        cfg_addr  <= ADDR_W'(i);
        cfg_wdata <= val;
        @(posedge clk);
        sb.note_config(ADDR_W'(i), val);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // One sample transfer. Valid is only dropped when a gap is taken, so it
  // never gets two assignments in one step.
  task automatic send_sample(input logic signed [DATA_W-1:0] sp,
                             input logic signed [DATA_W-1:0] fb);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fb, sp};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(sp, fb);
  endtask

  // Random sample: mostly a loop tracking its setpoint (small error),
  // some unrelated pairs and some at the range limits.
  task automatic send_random();
    logic signed [DATA_W-1:0] sp;
    logic signed [DATA_W-1:0] fb;
    sp = DATA_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    fb = DATA_W'($urandom);
      2: begin
        sp = pick_edge();
        fb = pick_edge();
      end
      default: fb = sp + DATA_W'($urandom_range(0, 64)) - 16'sd32;
    endcase
    send_sample(sp, fb);
  endtask

  // --------------------------------------------------------------------------
  // Result side: monitor and ready pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
      n_results++;
    end
  end

  // Ready gaps of random length; at set result counts the sink holds off for
  // a long stretch so that the block backs up and stalls its input.
  initial begin : result_sink
    int unsigned hold;
    int unsigned next_squeeze;
    hold = 0;
    next_squeeze = SQUEEZE_FIRST;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (n_results >= next_squeeze) begin
        hold = SQUEEZE_CYCLES;
        next_squeeze += SQUEEZE_EVERY;
      end else if (hold == 0 && rx_idle_en) begin
        hold = pick_gap();
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t        setting;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: gains zero, so outputs are zero; the integral still
    // builds with the reset period and shows up once ki is set.
    send_sample('0, '0);
    send_sample(S16_MAX, S16_MIN);
    send_sample(S16_MIN, S16_MAX);
    send_sample('1, '1);

    // Unity gains only; period and rate keep their reset values.
    setting.gain_prop  = GAIN_ONE;
    setting.gain_integ = GAIN_ONE;
    setting.gain_deriv = GAIN_ONE;
    setting.dt_frac    = '0;
    setting.inv_dt     = '0;
    load_config(setting, GAIN_MASK);
    send_sample(16'sd100, '0);
    send_sample(16'sd100, 16'sd50);
    send_sample(-16'sd200, 16'sd300);
    send_sample(S16_MAX, S16_MIN);

    // Full-scale gains and period: derivative swings clamp the output both
    // ways. Unmapped indexes are written too.
    setting.gain_prop  = S16_MAX;
    setting.gain_integ = S16_MIN;
    setting.gain_deriv = S16_MAX;
    setting.dt_frac    = '1;
    setting.inv_dt     = '1;
    load_config(setting, ALL_MASK);
    send_sample(S16_MAX, S16_MIN);
    send_sample(S16_MIN, S16_MAX);
    send_sample('0, '0);
    send_sample(S16_MIN, S16_MAX);
    send_sample(S16_MIN, S16_MAX);

    // Zero period and zero rate: integral frozen, derivative term zero.
    setting.gain_prop  = S16_MIN;
    setting.gain_integ = S16_MAX;
    setting.gain_deriv = S16_MIN;
    setting.dt_frac    = '0;
    setting.inv_dt     = '0;
    load_config(setting, KNOWN_MASK);
    send_sample(S16_MAX, S16_MIN);
    send_sample(S16_MIN, S16_MAX);
    send_sample(16'sd1, '0);
    send_sample('0, '0);

    // Smallest nonzero period and rate, gains of -1 LSB (floor rounding).
    setting.gain_prop  = '1;
    setting.gain_integ = '1;
    setting.gain_deriv = '1;
    setting.dt_frac    = DATA_W'(1);
    setting.inv_dt     = DATA_W'(1);
    load_config(setting, KNOWN_MASK);
    send_sample(S16_MAX, S16_MIN);
    send_sample(S16_MIN, S16_MIN);
    send_sample(S16_MIN, S16_MAX);
    send_sample(16'sd5, -16'sd3);

    // Random phases, each with its own register setting and idle pattern.
    for (int p = 0; p < RAND_PHASES; p++) begin
      setting.gain_prop  = rand_gain();
      setting.gain_integ = rand_gain();
      setting.gain_deriv = rand_gain();
      setting.dt_frac    = rand_period();
      setting.inv_dt     = rand_period();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      load_config(setting, ($urandom_range(0, 3) == 0) ? ALL_MASK : KNOWN_MASK);
      repeat (ITEMS_PER_PHASE) send_random();
    end

    // Integral ramp: full-scale error at full period, back to back, builds
    // a large integral quickly. Only kp is set here.
    setting.gain_prop  = DATA_W'(1);
    setting.gain_integ = '0;
    setting.gain_deriv = '0;
    setting.dt_frac    = '1;
    setting.inv_dt     = '1;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    load_config(setting, KNOWN_MASK);
    repeat (RAMP_ITEMS) send_sample(S16_MAX, S16_MIN);
    repeat (3) send_sample(S16_MIN, S16_MAX);  // error reverses

    // Large integral with maximum ki and random kp and kd, both sides idling again.
    setting.gain_prop  = rand_gain();
    setting.gain_integ = S16_MAX;
    setting.gain_deriv = rand_gain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    load_config(setting, GAIN_MASK);
    repeat (20) send_random();

    in_tvalid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("[pid_controller_step_unit] OK");
    end else begin
      $display("[pid_controller_step_unit] ERROR");
    end
    $finish;
  end

endmodule
